@@ design/chte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants of the chained hash table engine: request
// codes, result status codes, the key hash constants and the key and value widths.
// ----------------------------------------------------------------------------
package chte_pkg;

  // Request kind, carried on in_tuser
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_PUT    = 1'b1
  } op_t;

  // Result status, carried on out_tuser[2:1]
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  localparam logic [31:0] HASH_MULT  = 32'h045d_9f3b;
  localparam int          HASH_SHIFT = 16;
  localparam int          KEY_W      = 32;
  localparam int          VAL_W      = 32;

endpackage
`default_nettype wire

@@ design/chte_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_ram
// Generic single-clock RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/chained_hash_table_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Steps: the input transfer reaches out_tvalid through hash multiply,
//   magnitude, reciprocal multiply, bucket select with row read, compare.
// Flow: one request at a time; a new one is taken only after the last leaves
//   the compare state, which waits while a result is not taken.
// Reset: synchronous, active low; then a clearing pass writes every
//   bucket row to zero (no request taken meanwhile).
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Key/value table with BUCKETS buckets of WAYS fixed ways. Each bucket is one
// RAM row holding the valid bits, keys and values of all its ways; a request
// reads the row, compares all ways in parallel and writes the row back.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] key, [63:32] data_in
  input  wire logic [0:0]  in_tuser,   // [0] op (0 lookup, 1 put)
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] data_out
  output logic [2:0]       out_tuser   // [0] found, [2:1] status
);

  import chte_pkg::*;

  // Row layout: keys in the low bits, then values, then one valid bit per way
  localparam int KEY_OFF = 0;
  localparam int VAL_OFF = WAYS * KEY_W;
  localparam int VLD_OFF = VAL_OFF + WAYS * VAL_W;
  localparam int ROW_W   = VLD_OFF + WAYS;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Reciprocal for the bucket reduction: floor(2^32 / BUCKETS). The estimated
  // quotient is at most one short, so one compare and subtract corrects it.
  localparam logic [31:0] RECIP     = 32'(64'h1_0000_0000 / BUCKETS);
  localparam logic [31:0] BUCKETS_W = 32'(BUCKETS);
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MAG,
    ST_QUOT,
    ST_BKT,
    ST_CMP
  } state_t;

  // Control registers
  state_t           state_r,     state_nxt;
  logic [BKT_W-1:0] clr_cnt_r,   clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request and pipeline payload registers
  logic             op_r;
  logic [31:0]      key_r;
  logic [31:0]      data_in_r;
  logic [31:0]      t_r;
  logic [31:0]      mag_r;
  logic [31:0]      q_r;
  logic [BKT_W-1:0] bkt_r;
  logic             found_r,  found_nxt;
  logic [31:0]      data_r,   data_nxt;
  status_t          status_r, status_nxt;

  // Hash datapath
  logic [31:0] mix_c;
  logic [31:0] t_prod_c;
  logic [31:0] t2_c;
  logic [31:0] mag_c;
  logic [63:0] q_prod_c;
  logic [31:0] qb_c;
  logic [31:0] rem_c;
  logic [31:0] rem_fix_c;
  logic [BKT_W-1:0] bkt_c;

  // RAM ports
  logic             ram_wr_en;
  logic [BKT_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [ROW_W-1:0] ram_rd_data;

  // Way compare
  logic             hit_c;
  logic [WAY_W-1:0] hit_idx_c;
  logic             free_c;
  logic [WAY_W-1:0] free_idx_c;
  logic [31:0]      hit_val_c;
  logic [ROW_W-1:0] new_row_c;
  logic             advance_c;
  logic             accept_c;

  chte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (bkt_c),
    .rd_data (ram_rd_data)
  );

  // --------------------------------------------------------------------------
  // Hash: xor-shift (arithmetic), multiply, xor-shift (logical), magnitude,
  // then reduce modulo BUCKETS through the reciprocal.
  // --------------------------------------------------------------------------
  assign mix_c    = {{HASH_SHIFT{key_r[31]}}, key_r[31:HASH_SHIFT]} ^ key_r;
  assign t_prod_c = mix_c * HASH_MULT;
  assign t2_c     = {{HASH_SHIFT{1'b0}}, t_r[31:HASH_SHIFT]} ^ t_r;
  // 0x80000000 negates to itself, which read unsigned is 2^31
  assign mag_c    = t2_c[31] ? (~t2_c + 32'd1) : t2_c;
  assign q_prod_c = {32'd0, mag_r} * {32'd0, RECIP};
  assign qb_c     = q_r * BUCKETS_W;
  assign rem_c    = mag_r - qb_c;
  assign rem_fix_c = (rem_c >= BUCKETS_W) ? (rem_c - BUCKETS_W) : rem_c;
  assign bkt_c    = rem_fix_c[BKT_W-1:0];

  // --------------------------------------------------------------------------
  // Way compare on the row just read: lowest valid way holding the key, and
  // lowest free way.
  // --------------------------------------------------------------------------
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    hit_val_c  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (ram_rd_data[VLD_OFF + w]) begin
        if (!hit_c && (ram_rd_data[KEY_OFF + w*KEY_W +: KEY_W] == key_r)) begin
          hit_c     = 1'b1;
          hit_idx_c = WAY_W'(w);
          hit_val_c = ram_rd_data[VAL_OFF + w*VAL_W +: VAL_W];
        end
      end else if (!free_c) begin
        free_c     = 1'b1;
        free_idx_c = WAY_W'(w);
      end
    end
  end

  // Row written back by a put: replace the value on a hit, else claim the
  // free way
  always_comb begin
    new_row_c = ram_rd_data;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_c) begin
        if (hit_idx_c == WAY_W'(w)) begin
          new_row_c[VAL_OFF + w*VAL_W +: VAL_W] = data_in_r;
        end
      end else if (free_c && (free_idx_c == WAY_W'(w))) begin
        new_row_c[VLD_OFF + w]                = 1'b1;
        new_row_c[KEY_OFF + w*KEY_W +: KEY_W] = key_r;
        new_row_c[VAL_OFF + w*VAL_W +: VAL_W] = data_in_r;
      end
    end
  end

  // Leave the compare state only once the result register is free
  assign advance_c = (state_r == ST_CMP) && (!out_valid_r || out_tready);
  assign accept_c  = in_tvalid && in_tready;

  assign ram_rd_en = (state_r == ST_BKT);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = bkt_r;
    ram_wr_data = new_row_c;
    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
      end
      ST_CMP: begin
        ram_wr_en = advance_c && (op_r == OP_PUT) && (hit_c || free_c);
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    data_nxt      = data_r;
    status_nxt    = status_r;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + BKT_W'(1);
        if (clr_cnt_r == LAST_BKT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_c) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_QUOT;
      ST_QUOT: state_nxt = ST_BKT;
      ST_BKT:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (advance_c) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          found_nxt     = hit_c;
          if (op_r == OP_LOOKUP) begin
            data_nxt   = hit_c ? hit_val_c : 32'd0;
            status_nxt = hit_c ? STATUS_OK : STATUS_MISS;
          end else begin
            data_nxt   = 32'd0;
            status_nxt = (hit_c || free_c) ? STATUS_OK : STATUS_FULL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload: hold the request, advance the hash stages
    if (accept_c) begin
      op_r      <= in_tuser[0];
      key_r     <= in_tdata[31:0];
      data_in_r <= in_tdata[63:32];
    end
    if (state_r == ST_HASH) t_r   <= t_prod_c;
    if (state_r == ST_MAG)  mag_r <= mag_c;
    if (state_r == ST_QUOT) q_r   <= q_prod_c[63:32];
    if (state_r == ST_BKT)  bkt_r <= bkt_c;
    found_r  <= found_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {status_r, found_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept_c |=> !in_tready)
    else $error("request taken while another is in flight");

  a_wr_only_clear_or_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ((state_r == ST_CLEAR) || (state_r == ST_CMP)))
    else $error("row RAM written outside clear pass or compare");

  a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (status_r == STATUS_OK))
    else $error("found result with a failure status");

  a_miss_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (data_r == 32'd0))
    else $error("non-zero data on a result without a hit");

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BKT) |-> (rem_fix_c < BUCKETS_W))
    else $error("bucket reduction out of range");

endmodule
`default_nettype wire

@@ verif/tb_chained_hash_table_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table_engine
// Self-checking bench for the bucketed key/value table. Each request
// transfer is run through a local copy of the table to work out its reply.
// Every reply transfer is then compared with the oldest outstanding reply.
// Directed tests cover the empty table, hits and updates on extreme keys and
// values, the hash magnitude overflow key and a bucket filled to overflow.
// Random traffic follows: a bounded key pool drives the table to
// saturation. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine;
  import chte_pkg::*;

  localparam int BUCKETS      = 16;
  localparam int WAYS         = 8;
  localparam int ENTRIES      = BUCKETS * WAYS;
  localparam int RANDOM_ITEMS = 550;
  // More pool keys than table entries, so that buckets overflow
  localparam int POOL_SIZE    = 192;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;
  // Slowest run is about 600 items with the longest gaps; allow several times that
  localparam int CYCLE_LIMIT  = 200000;

  // One reply of the table, in the order of the reply fields
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] data_out;
    status_t          status;
  } table_reply_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] key, [63:32] data_in
  logic [0:0]  in_tuser   = '0;   // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] data_out
  logic [2:0]  out_tuser;         // [0] found, [2:1] status

  // Local copy of the table, way w of bucket b at b*WAYS+w
  bit               table_valid [ENTRIES];
  logic [KEY_W-1:0] table_key   [ENTRIES];
  logic [VAL_W-1:0] table_value [ENTRIES];

  table_reply_t pending_replies[$];
  table_reply_t oldest_reply;
  int unsigned  mismatches  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left  = 0;
  int unsigned  next_stall;
  // Set for stretches of traffic with no idling on either side
  bit           idle_off    = 1'b0;

  always #5 clk = ~clk;

  chained_hash_table_engine #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic int unsigned idle_cycles();
    return idle_off ? 0 : $urandom_range(0, 15);
  endfunction

  // Raw hash word: xor-shift with sign fill, multiply, logical xor-shift
  function automatic logic [31:0] key_hash(logic [KEY_W-1:0] k);
    logic signed [31:0] ks;
    logic [31:0]        t;
    ks = k;
    t  = ks >>> HASH_SHIFT;
    t  = (t ^ k) * HASH_MULT;
    t  = (t >> HASH_SHIFT) ^ t;
    return t;
  endfunction

  // Bucket of a key: magnitude of the hash word taken as signed, modulo
  // BUCKETS; the most negative word stays as 2^31
  function automatic int bucket_index(logic [KEY_W-1:0] k);
    logic [31:0] t;
    logic [31:0] mag;
    t   = key_hash(k);
    mag = t[31] ? (~t + 32'd1) : t;
    return mag % BUCKETS;
  endfunction

  // Apply one request to the local table and return the reply it earns
  function automatic table_reply_t table_apply(op_t op, logic [KEY_W-1:0] k,
                                               logic [VAL_W-1:0] v);
    table_reply_t r;
    int           base;
    int           hit;
    int           free_way;
    base     = bucket_index(k) * WAYS;
    hit      = -1;
    free_way = -1;
    r.found    = 1'b0;
    r.data_out = '0;
    r.status   = STATUS_OK;
    for (int w = 0; w < WAYS; w++) begin
      if (table_valid[base + w]) begin
        if (hit < 0 && table_key[base + w] == k) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (op == OP_LOOKUP) begin
      if (hit >= 0) begin
        r.found    = 1'b1;
        r.data_out = table_value[base + hit];
      end else begin
        r.status = STATUS_MISS;
      end
    end else if (hit >= 0) begin
      r.found                = 1'b1;
      table_value[base + hit] = v;
    end else if (free_way >= 0) begin
      table_valid[base + free_way] = 1'b1;
      table_key[base + free_way]   = k;
      table_value[base + free_way] = v;
    end else begin
      r.status = STATUS_FULL;
    end
    return r;
  endfunction

  // Key whose raw hash word is exactly the most negative word: undo the
  // final xor-shift, then the multiply (Newton inverse), then the first
  // xor-shift
  function automatic logic [KEY_W-1:0] overflow_key();
    logic [31:0] inv;
    logic [31:0] x;
    inv = HASH_MULT;
    repeat (5) inv = inv * (32'd2 - HASH_MULT * inv);
    x = 32'h8000_8000 * inv;
    return {x[31:16], x[15:0] ^ x[31:16]};
  endfunction

  // Offer one request after a random gap and hold it until the transfer.
  // Keep tvalid high across back-to-back requests.
  task automatic send_request(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int unsigned  gap;
    table_reply_t expected;
    gap = idle_cycles();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected        = table_apply(op, k, v);
    pending_replies = {pending_replies, expected};
  endtask

  task automatic test_empty_lookups();
    send_request(OP_LOOKUP, 32'h8000_0000, $urandom);
    send_request(OP_LOOKUP, 32'h0000_0000, $urandom);
  endtask

  // Store the extreme keys with extreme values, read back, update, read back
  task automatic test_put_and_hit();
    send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_LOOKUP, 32'h8000_0000, $urandom);
    send_request(OP_LOOKUP, 32'h7fff_ffff, $urandom);
    send_request(OP_LOOKUP, 32'h0000_0000, $urandom);
    send_request(OP_LOOKUP, 32'hffff_ffff, $urandom);
    send_request(OP_PUT, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h8000_0000, $urandom);
    send_request(OP_LOOKUP, 32'hffff_ffff, $urandom);
  endtask

  task automatic test_magnitude_overflow();
    logic [KEY_W-1:0] k;
    k = overflow_key();
    send_request(OP_PUT, k, $urandom);
    send_request(OP_LOOKUP, k, $urandom);
  endtask

  // Fill one bucket, push one key past its last way, then check that the
  // dropped key is absent and that a stored key still updates
  task automatic test_full_bucket();
    int               target;
    int               used;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] first_key;
    target = $urandom_range(0, BUCKETS - 1);
    used   = 0;
    for (int w = 0; w < WAYS; w++) used += table_valid[target * WAYS + w];
    first_key = '0;
    for (int i = 0; i <= WAYS - used; i++) begin
      do k = $urandom; while (bucket_index(k) != target);
      if (i == 0) first_key = k;
      send_request(OP_PUT, k, $urandom);
    end
    send_request(OP_LOOKUP, k, $urandom);
    if (used < WAYS) begin
      send_request(OP_PUT, first_key, $urandom);
      send_request(OP_LOOKUP, first_key, $urandom);
    end
  endtask

  // Mostly pool keys, so puts hit and buckets saturate; the rest are fresh
  // random keys that miss or overflow
  task automatic test_random_traffic();
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KEY_W-1:0] k;
    op_t              op;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) idle_off = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else k = $urandom;
      op = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_LOOKUP;
      send_request(op, k, $urandom);
    end
  endtask

  // Result side: after each transfer, drop tready for a random stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        next_stall = idle_cycles();
        if (next_stall != 0) begin
          out_tready <= 1'b0;
          stall_left <= next_stall - 1;
        end
      end
    end else if (stall_left == 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Compare each reply transfer with the oldest outstanding reply
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: reply with none outstanding: found %0d data_out %h status %0d",
                   cycle_count, out_tuser[0], out_tdata, out_tuser[2:1]);
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (out_tuser[0] !== oldest_reply.found || out_tdata !== oldest_reply.data_out ||
            out_tuser[2:1] !== oldest_reply.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: expected found %0d data_out %h status %0d, got %0d %h %0d",
                     cycle_count, oldest_reply.found, oldest_reply.data_out,
                     oldest_reply.status, out_tuser[0], out_tdata, out_tuser[2:1]);
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_chained_hash_table_engine failed");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release; the clearing pass shows as tready held low
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_lookups();
    test_put_and_hit();
    test_magnitude_overflow();
    test_full_bucket();
    test_random_traffic();
    in_tvalid <= 1'b0;
    // Drain outstanding replies, then watch for strays
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_chained_hash_table_engine passed");
    end else begin
      $display("tb_chained_hash_table_engine failed");
    end
    $finish;
  end

endmodule
